/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the feature admission block
// depends on nothing; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define GBFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
// same-cycle implication
`define GBFA_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("implication failed");
`else
`define GBFA_ASSERT(lbl, clk, rst, prop)
`define GBFA_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/gbfa_pkg.sv */
// types, codes and default sizes of the grid bucketed feature admission block
// depends on nothing; imported by the divider and the top level
package gbfa_pkg;

   localparam int MAX_BLOCKS_DEF     = 256;
   localparam int BLOCK_CAPACITY_DEF = 16;

   localparam int COORD_W = 16;
   localparam int GRID_W  = 9;
   localparam int LIMIT_W = 5;
   localparam int COUNT_W = 13;
   localparam int BIDX_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_REF   = 2'd1,
      KIND_CAND  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEARED    = 3'd0,
      ST_REF_STORED = 3'd1,
      ST_REF_FULL   = 3'd2,
      ST_ACCEPTED   = 3'd3,
      ST_OUTSIDE    = 3'd4,
      ST_NEAR_EDGE  = 3'd5,
      ST_BLOCK_FULL = 3'd6,
      ST_TOO_CLOSE  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CSR_BLOCK_WIDTH  = 3'd0,
      CSR_BLOCK_HEIGHT = 3'd1,
      CSR_GRID_COLUMNS = 3'd2,
      CSR_GRID_ROWS    = 3'd3,
      CSR_ORIGIN_X     = 3'd4,
      CSR_ORIGIN_Y     = 3'd5,
      CSR_MIN_SPACING  = 3'd6,
      CSR_OCC_LIMIT    = 3'd7
   } csr_index_type;

endpackage

/* rtl/gbfa_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module gbfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/gbfa_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on gbfa_pkg for the coordinate width
module gbfa_div import gbfa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] dividend,
   input  logic [COORD_W-1:0] divisor,
   output logic               done,
   output logic [COORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(COORD_W + 1);

   logic [COORD_W:0]   rem_ff;
   logic [COORD_W-1:0] quo_ff;
   logic [COORD_W-1:0] dvs_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [COORD_W:0]   rem_sh;
   logic               take;

   // trial subtraction of the shifted remainder
   always_comb begin
      rem_sh = {rem_ff[COORD_W-1:0], quo_ff[COORD_W-1]};
      take   = rem_sh >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(COORD_W);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= take ? rem_sh - {1'b0, dvs_ff} : rem_sh;
            quo_ff <= {quo_ff[COORD_W-2:0], take};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/grid_bucketed_feature_admission.sv */
// top level of the grid bucketed feature admission block
// depends on gbfa_pkg, gbfa_ram, gbfa_div and assert_macros.svh
//
// Spreads feature points over a grid of blocks. Requests arrive on req_*
// (tuser: kind; tdata: pos_x, pos_y); one response per request leaves on
// rsp_* (tuser: status; tdata: block_index, accepted_count). Kind 3 is taken
// and produces no response. Registers are written on csr_* at any time the
// block is idle; csr_ready is always high.
// A point in the grid is placed in its block by the two 16-bit bit-serial
// dividers that find the column and row; a candidate is then checked against
// each stored point of its block, walked one entry at a time through the store.
// One request is in work at a time; the next is taken once the response is
// loaded into the output register, even if the receiver has not taken it.
// A stalled receiver holds the response and the finished request waits.
// Reset loads the register defaults, empties every block (valid bits over
// the fill table are cleared at once) and zeroes the accepted count.
`include "assert_macros.svh"
module grid_bucketed_feature_admission import gbfa_pkg::*; #(
   parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
   parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // pos_x [15:0], pos_y [31:16]
   input  logic [1:0]  req_tuser,  // kind [1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // block_index [7:0], accepted_count [20:8], zero [23:21]
   output logic [2:0]  rsp_tuser,  // status [2:0]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int BI_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int SA_D   = MAX_BLOCKS * BLOCK_CAPACITY;
   localparam int SA_W   = (SA_D > 1) ? $clog2(SA_D) : 1;
   localparam int FILL_W = $clog2(BLOCK_CAPACITY + 1);
   localparam int RX_W   = GRID_W + COORD_W;
   localparam int EDGE_W = RX_W + 2;
   localparam int IDX_W  = 2 * GRID_W + 1;
   localparam int SQ_W   = 2 * COORD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_GEO, S_CHK, S_DIV, S_MUL, S_IDX, S_FILL,
      S_RD, S_DIF, S_SQ, S_CMP, S_ADD, S_OUT
   } state_type;

   function automatic logic [EDGE_W-1:0] absd(input logic [EDGE_W-1:0] a,
                                             input logic [EDGE_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // configuration registers
   logic [COORD_W-1:0] bw_ff, bh_ff, ox_ff, oy_ff, ms_ff;
   logic [GRID_W-1:0]  gc_ff, gr_ff;
   logic [LIMIT_W-1:0] lim_ff;

   // item and work registers
   state_type          state_ff;
   kind_type           kind_ff;
   logic [COORD_W-1:0] px_ff, py_ff;
   logic [RX_W-1:0]    rx_ff, ry_ff;
   logic [SQ_W-1:0]    d2_ff;
   logic [GRID_W-1:0]  col_ff, row_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [EDGE_W-1:0]  xl_ff, yt_ff;
   logic [SA_W-1:0]    base_ff;
   logic [FILL_W-1:0]  fill_ff, k_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   status_type         status_ff;
   logic [BIDX_W-1:0]  bidx_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [MAX_BLOCKS-1:0] fill_vld_ff;
   logic               fill_hit_ff;

   // response register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [BIDX_W-1:0]  rsp_bidx_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // datapath
   logic [BI_W-1:0]    bi;
   logic [EDGE_W-1:0]  px_e, py_e, right, bottom, xr, yb, d_e;
   logic [RX_W-1:0]    rx_prod, ry_prod;
   logic               zero_geo, in_grid, near_edge;
   logic [FILL_W-1:0]  fill_rd, fill_cur, fill_wdata;
   logic               fill_we, store_we;
   logic [SA_W-1:0]    store_raddr, store_waddr;
   logic [31:0]        store_rd;
   logic               div_start, div_x_done, div_y_done;
   logic [COORD_W-1:0] qx, qy;
   logic [SQ_W:0]      dist2;
   logic               req_acc, rsp_free;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign bi       = idx_ff[BI_W-1:0];

   // geometry and comparisons
   always_comb begin
      rx_prod   = RX_W'(gc_ff) * RX_W'(bw_ff);
      ry_prod   = RX_W'(gr_ff) * RX_W'(bh_ff);
      px_e      = EDGE_W'(px_ff);
      py_e      = EDGE_W'(py_ff);
      d_e       = EDGE_W'(ms_ff);
      right     = EDGE_W'(ox_ff) + EDGE_W'(rx_ff);
      bottom    = EDGE_W'(oy_ff) + EDGE_W'(ry_ff);
      zero_geo  = (bw_ff == '0) || (bh_ff == '0) || (gc_ff == '0) || (gr_ff == '0);
      in_grid   = !zero_geo && (px_ff > ox_ff) && (py_ff > oy_ff) &&
                  (px_e < right) && (py_e < bottom);
      xr        = xl_ff + EDGE_W'(bw_ff);
      yb        = yt_ff + EDGE_W'(bh_ff);
      near_edge = (absd(px_e, xl_ff) < d_e) || (absd(px_e, xr) < d_e) ||
                  (absd(py_e, yt_ff) < d_e) || (absd(py_e, yb) < d_e);
      fill_cur  = fill_hit_ff ? fill_rd : '0;
      dist2     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   // memory controls
   always_comb begin
      fill_we     = state_ff == S_ADD;
      store_we    = state_ff == S_ADD;
      fill_wdata  = fill_ff + 1'b1;
      store_raddr = base_ff + SA_W'(k_ff);
      store_waddr = base_ff + SA_W'(fill_ff);
      div_start   = (state_ff == S_CHK) && in_grid;
   end

   gbfa_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BLOCKS)) u_fill (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (bi),
      .wr_data (fill_wdata),
      .rd_addr (bi),
      .rd_data (fill_rd)
   );

   gbfa_ram #(.WIDTH(32), .DEPTH(SA_D)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data ({py_ff, px_ff}),
      .rd_addr (store_raddr),
      .rd_data (store_rd)
   );

   gbfa_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (px_ff - ox_ff),
      .divisor  (bw_ff),
      .done     (div_x_done),
      .quotient (qx)
   );

   gbfa_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (py_ff - oy_ff),
      .divisor  (bh_ff),
      .done     (div_y_done),
      .quotient (qy)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= 16'd512;
         bh_ff  <= 16'd512;
         gc_ff  <= 9'd16;
         gr_ff  <= 9'd16;
         ox_ff  <= '0;
         oy_ff  <= '0;
         ms_ff  <= 16'd160;
         lim_ff <= 5'd2;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_WIDTH:  bw_ff  <= csr_data;
            CSR_BLOCK_HEIGHT: bh_ff  <= csr_data;
            CSR_GRID_COLUMNS: gc_ff  <= csr_data[GRID_W-1:0];
            CSR_GRID_ROWS:    gr_ff  <= csr_data[GRID_W-1:0];
            CSR_ORIGIN_X:     ox_ff  <= csr_data;
            CSR_ORIGIN_Y:     oy_ff  <= csr_data;
            CSR_MIN_SPACING:  ms_ff  <= csr_data;
            CSR_OCC_LIMIT:    lim_ff <= csr_data[LIMIT_W-1:0];
            default:          lim_ff <= lim_ff;
         endcase
      end
   end

   // request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         fill_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response taken and nothing new loaded this cycle
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  kind_ff <= kind_type'(req_tuser);
                  px_ff   <= req_tdata[15:0];
                  py_ff   <= req_tdata[31:16];
                  bidx_ff <= '0;
                  priority case (kind_type'(req_tuser))
                     KIND_CLEAR: begin
                        fill_vld_ff <= '0;
                        total_ff    <= '0;
                        status_ff   <= ST_CLEARED;
                        state_ff    <= S_OUT;
                     end
                     KIND_NONE: state_ff <= S_IDLE;
                     default:   state_ff <= S_GEO;
                  endcase
               end
            end
            S_GEO: begin
               rx_ff    <= rx_prod;
               ry_ff    <= ry_prod;
               d2_ff    <= SQ_W'(ms_ff) * SQ_W'(ms_ff);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (in_grid) begin
                  state_ff <= S_DIV;
               end else begin
                  status_ff <= ST_OUTSIDE;
                  state_ff  <= S_OUT;
               end
            end
            S_DIV: begin
               if (div_x_done) begin
                  col_ff   <= qx[GRID_W-1:0];
                  row_ff   <= qy[GRID_W-1:0];
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               idx_ff   <= IDX_W'(row_ff) * IDX_W'(gc_ff) + IDX_W'(col_ff);
               xl_ff    <= EDGE_W'(col_ff) * EDGE_W'(bw_ff) + EDGE_W'(ox_ff);
               yt_ff    <= EDGE_W'(row_ff) * EDGE_W'(bh_ff) + EDGE_W'(oy_ff);
               state_ff <= S_IDX;
            end
            S_IDX: begin
               // block beyond the store counts as outside
               if (idx_ff >= IDX_W'(MAX_BLOCKS)) begin
                  status_ff <= ST_OUTSIDE;
                  state_ff  <= S_OUT;
               end else begin
                  fill_hit_ff <= fill_vld_ff[bi];
                  base_ff     <= SA_W'(bi * BLOCK_CAPACITY);
                  bidx_ff     <= idx_ff[BIDX_W-1:0];
                  state_ff    <= S_FILL;
               end
            end
            S_FILL: begin
               fill_ff <= fill_cur;
               k_ff    <= '0;
               if (kind_ff == KIND_REF) begin
                  if (fill_cur >= FILL_W'(BLOCK_CAPACITY)) begin
                     status_ff <= ST_REF_FULL;
                     state_ff  <= S_OUT;
                  end else begin
                     state_ff <= S_ADD;
                  end
               end else if (near_edge) begin
                  status_ff <= ST_NEAR_EDGE;
                  state_ff  <= S_OUT;
               end else if ((6'(fill_cur) >= 6'(lim_ff)) ||
                            (fill_cur >= FILL_W'(BLOCK_CAPACITY))) begin
                  status_ff <= ST_BLOCK_FULL;
                  state_ff  <= S_OUT;
               end else if (fill_cur == '0) begin
                  state_ff <= S_ADD;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_DIF;
            S_DIF: begin
               dx_ff    <= (px_ff > store_rd[15:0]) ? px_ff - store_rd[15:0]
                                                    : store_rd[15:0] - px_ff;
               dy_ff    <= (py_ff > store_rd[31:16]) ? py_ff - store_rd[31:16]
                                                     : store_rd[31:16] - py_ff;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               sqx_ff   <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
               sqy_ff   <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (dist2 <= {1'b0, d2_ff}) begin
                  status_ff <= ST_TOO_CLOSE;
                  state_ff  <= S_OUT;
               end else if (k_ff + 1'b1 == fill_ff) begin
                  state_ff <= S_ADD;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_ADD: begin
               // store and fill writes happen this cycle
               fill_vld_ff[bi] <= 1'b1;
               if (kind_ff == KIND_REF) begin
                  status_ff <= ST_REF_STORED;
               end else begin
                  status_ff <= ST_ACCEPTED;
                  if (total_ff != COUNT_MAX) begin
                     total_ff <= total_ff + 1'b1;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_bidx_ff   <= bidx_ff;
                  rsp_count_ff  <= total_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_bidx_ff};

   // checks
   `GBFA_IMPLY(a_acc_count, clock, reset, rsp_tvalid && rsp_tready && rsp_status_ff == ST_ACCEPTED, rsp_count_ff != '0)
   `GBFA_IMPLY(a_clear_rsp, clock, reset, rsp_tvalid && rsp_status_ff == ST_CLEARED, rsp_count_ff == '0 && rsp_bidx_ff == '0)
   `GBFA_ASSERT(a_div_sync, clock, reset, div_x_done == div_y_done)
   `GBFA_IMPLY(a_fill_cap, clock, reset, fill_we, fill_wdata <= FILL_W'(BLOCK_CAPACITY))

endmodule
